// ===== rtl/c_source_bracket_checker_defines.svh =====
// Assertion macros used by the bracket checker stack.
`ifndef C_SOURCE_BRACKET_CHECKER_DEFINES_SVH
`define C_SOURCE_BRACKET_CHECKER_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define CSBC_ASSERT_NOW(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bracket checker assertion failed");

// Check that a condition implies another in the following cycle.
`define CSBC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bracket checker assertion failed");

`endif

// ===== rtl/csbc_pkg.sv =====
// Shared types and character constants for the bracket checker.
package csbc_pkg;

	// Lexer modes
	typedef enum logic [3:0] {
		LEX_NORMAL   = 4'd0,
		LEX_CHR      = 4'd1,
		LEX_CHR_ESC  = 4'd2,
		LEX_STR      = 4'd3,
		LEX_STR_ESC  = 4'd4,
		LEX_SLASH    = 4'd5,
		LEX_LINE_CMT = 4'd6,
		LEX_BLK_CMT  = 4'd7,
		LEX_BLK_STAR = 4'd8
	} lex_mode_t;

	// Report kinds
	typedef enum logic [1:0] {
		RPT_UNMATCHED = 2'd0,
		RPT_UNCLOSED  = 2'd1,
		RPT_CLEAN     = 2'd2,
		RPT_OVERFLOW  = 2'd3
	} report_kind_t;

	// Command codes
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// Characters the lexer cares about
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_SQUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE  = 8'h22;

	localparam int OUT_LINE_W = 20;
	typedef logic [OUT_LINE_W-1:0] line_out_t;

	// Bracket event from the lexer to the stack
	typedef struct packed {
		logic open;
		logic close;
		logic curly;
		logic end_mark;
	} brk_ev_t;

	// Result word
	typedef struct packed {
		report_kind_t kind;
		logic [7:0]   chr;
		line_out_t    line;
		logic         any_error;
	} report_t;

endpackage

// ===== rtl/c_source_bracket_checker.sv =====
// A result word is registered as its source word leaves the input register. Throughput: one
// word per cycle unless a report waits on a full result register; each word takes one lexer
// step and at most one stack push or pop, with the stack top and the entry under it held in
// registers in front of the memory. Reset: lexer, line counter, stack depth, error flag and
// handshakes clear asynchronously; not the stack memory. An end marker resets all but the handshakes.
module c_source_bracket_checker #(
	parameter int STACK_DEPTH = 64,
	parameter int LINE_BITS   = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  char_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  report_kind,
	output logic [7:0]  bracket_char,
	output logic [19:0] line_number,
	output logic        any_error
);

	logic                 valid_s1;
	logic                 cmd_s1;
	logic [7:0]           char_s1;
	logic                 out_valid_q;
	csbc_pkg::report_t    report_q;
	csbc_pkg::report_t    report;
	csbc_pkg::brk_ev_t    ev;
	logic [LINE_BITS-1:0] cur_line;
	logic                 has_result;
	logic                 out_free, advance, load;

	// Advance a word unless it needs the result register and that is still full
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!has_result || out_free);
	assign load     = advance && has_result;
	assign in_ready = !valid_s1 || advance;

	csbc_lexer #(
		.LINE_BITS(LINE_BITS)
	) u_lexer (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.cmd_s1  (cmd_s1),
		.char_s1 (char_s1),
		.ev      (ev),
		.line    (cur_line)
	);

	csbc_stack #(
		.STACK_DEPTH(STACK_DEPTH),
		.LINE_BITS  (LINE_BITS)
	) u_stack (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.ev         (ev),
		.char_s1    (char_s1),
		.cur_line   (cur_line),
		.has_result (has_result),
		.report     (report)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= cmd;
			char_s1 <= char_byte;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) report_q <= report;
	end

	assign out_valid    = out_valid_q;
	assign report_kind  = report_q.kind;
	assign bracket_char = report_q.chr;
	assign line_number  = report_q.line;
	assign any_error    = report_q.any_error;

endmodule

// ===== rtl/csbc_lexer.sv =====
// Lexer state machine: skips literals and comments, counts lines, flags brackets.
module csbc_lexer #(
	parameter int LINE_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  logic                  cmd_s1,
	input  logic [7:0]            char_s1,
	output csbc_pkg::brk_ev_t     ev,
	output logic [LINE_BITS-1:0]  line
);

	csbc_pkg::lex_mode_t mode_q, mode_d;
	logic [LINE_BITS-1:0] line_q;
	logic bump;
	logic as_normal;
	logic is_end;

	assign is_end = (cmd_s1 == csbc_pkg::CMD_END);

	// Byte is handled as ordinary source (also the byte after a lone slash)
	always_comb begin
		case (mode_q)
			csbc_pkg::LEX_NORMAL:   as_normal = 1'b1;
			csbc_pkg::LEX_SLASH:    as_normal = (char_s1 != csbc_pkg::CH_SLASH) &&
				(char_s1 != csbc_pkg::CH_STAR);
			csbc_pkg::LEX_CHR,
			csbc_pkg::LEX_CHR_ESC,
			csbc_pkg::LEX_STR,
			csbc_pkg::LEX_STR_ESC,
			csbc_pkg::LEX_LINE_CMT,
			csbc_pkg::LEX_BLK_CMT,
			csbc_pkg::LEX_BLK_STAR: as_normal = 1'b0;
			default:                as_normal = 1'b1;
		endcase
	end

	// Next mode and line bump
	always_comb begin
		mode_d = mode_q;
		bump = 1'b0;
		if (as_normal) begin
			mode_d = csbc_pkg::LEX_NORMAL;
			case (char_s1)
				csbc_pkg::CH_NL:     bump = 1'b1;
				csbc_pkg::CH_SQUOTE: mode_d = csbc_pkg::LEX_CHR;
				csbc_pkg::CH_DQUOTE: mode_d = csbc_pkg::LEX_STR;
				csbc_pkg::CH_SLASH:  mode_d = csbc_pkg::LEX_SLASH;
				default:             mode_d = csbc_pkg::LEX_NORMAL;
			endcase
		end else begin
			case (mode_q)
				csbc_pkg::LEX_CHR: begin
					if (char_s1 == csbc_pkg::CH_BSLASH) mode_d = csbc_pkg::LEX_CHR_ESC;
					else if (char_s1 == csbc_pkg::CH_SQUOTE) mode_d = csbc_pkg::LEX_NORMAL;
				end
				csbc_pkg::LEX_CHR_ESC: mode_d = csbc_pkg::LEX_CHR;
				csbc_pkg::LEX_STR: begin
					if (char_s1 == csbc_pkg::CH_BSLASH) mode_d = csbc_pkg::LEX_STR_ESC;
					else if (char_s1 == csbc_pkg::CH_DQUOTE) mode_d = csbc_pkg::LEX_NORMAL;
				end
				csbc_pkg::LEX_STR_ESC: mode_d = csbc_pkg::LEX_STR;
				csbc_pkg::LEX_SLASH: begin
					if (char_s1 == csbc_pkg::CH_SLASH) mode_d = csbc_pkg::LEX_LINE_CMT;
					else mode_d = csbc_pkg::LEX_BLK_CMT;
				end
				csbc_pkg::LEX_LINE_CMT: begin
					if (char_s1 == csbc_pkg::CH_NL) begin
						bump = 1'b1;
						mode_d = csbc_pkg::LEX_NORMAL;
					end
				end
				csbc_pkg::LEX_BLK_CMT: begin
					if (char_s1 == csbc_pkg::CH_NL) bump = 1'b1;
					else if (char_s1 == csbc_pkg::CH_STAR) mode_d = csbc_pkg::LEX_BLK_STAR;
				end
				csbc_pkg::LEX_BLK_STAR: begin
					if (char_s1 == csbc_pkg::CH_SLASH) begin
						mode_d = csbc_pkg::LEX_NORMAL;
					end else if (char_s1 != csbc_pkg::CH_STAR) begin
						bump = (char_s1 == csbc_pkg::CH_NL);
						mode_d = csbc_pkg::LEX_BLK_CMT;
					end
				end
				default: mode_d = csbc_pkg::LEX_NORMAL;
			endcase
		end
	end

	// Bracket events
	always_comb begin
		ev.end_mark = is_end;
		ev.open  = !is_end && as_normal &&
			((char_s1 == csbc_pkg::CH_LPAREN) || (char_s1 == csbc_pkg::CH_LBRACE));
		ev.close = !is_end && as_normal &&
			((char_s1 == csbc_pkg::CH_RPAREN) || (char_s1 == csbc_pkg::CH_RBRACE));
		ev.curly = (char_s1 == csbc_pkg::CH_LBRACE) || (char_s1 == csbc_pkg::CH_RBRACE);
	end

	assign line = line_q;

	// Advance mode and saturating line counter; end marker restarts the stream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= csbc_pkg::LEX_NORMAL;
			line_q <= LINE_BITS'(1);
		end else if (advance) begin
			if (is_end) begin
				mode_q <= csbc_pkg::LEX_NORMAL;
				line_q <= LINE_BITS'(1);
			end else begin
				mode_q <= mode_d;
				if (bump && (line_q != {LINE_BITS{1'b1}})) line_q <= line_q + LINE_BITS'(1);
			end
		end
	end

endmodule

// ===== rtl/csbc_stack.sv =====
// Bracket stack: top and next entry in registers, the rest in a memory; builds reports.
`include "c_source_bracket_checker_defines.svh"

module csbc_stack #(
	parameter int STACK_DEPTH = 64,
	parameter int LINE_BITS   = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  advance,
	input  csbc_pkg::brk_ev_t     ev,
	input  logic [7:0]            char_s1,
	input  logic [LINE_BITS-1:0]  cur_line,
	output logic                  has_result,
	output csbc_pkg::report_t     report
);

	localparam int DW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int EW = LINE_BITS + 1;

	logic [DW-1:0]        depth_q, depth_d;
	logic                 top_kind_q;
	logic [LINE_BITS-1:0] top_line_q;
	logic                 below_kind_q;
	logic [LINE_BITS-1:0] below_line_q;
	logic                 error_q;
	logic [EW-1:0]        mem [STACK_DEPTH];

	logic full, empty, match;
	logic push_ok, overflow, pop, unmatched;
	logic mem_we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata;
	logic err_d;

	assign full  = (depth_q == DW'(STACK_DEPTH));
	assign empty = (depth_q == '0);
	assign match = !empty && (top_kind_q == ev.curly);

	assign push_ok   = ev.open && !full;
	assign overflow  = ev.open && full;
	assign pop       = ev.close && match;
	assign unmatched = ev.close && !match;

	// Next depth
	always_comb begin
		depth_d = depth_q;
		if (advance) begin
			if (ev.end_mark) depth_d = '0;
			else if (push_ok) depth_d = depth_q + DW'(1);
			else if (pop) depth_d = depth_q - DW'(1);
		end
	end

	// Spill the old top on a push; prefetch the entry under the next top
	assign mem_we = advance && push_ok && !empty;
	assign waddr  = AW'(depth_q - DW'(1));
	assign wdata  = {top_kind_q, top_line_q};
	assign raddr  = AW'(depth_d - DW'(2));

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= wdata;
		if (mem_we && (waddr == raddr)) {below_kind_q, below_line_q} <= wdata;
		else {below_kind_q, below_line_q} <= mem[raddr];
	end

	// Report selection
	always_comb begin
		has_result = 1'b0;
		err_d = error_q;
		report.kind = csbc_pkg::RPT_CLEAN;
		report.chr  = char_s1;
		report.line = csbc_pkg::line_out_t'(cur_line);
		if (ev.end_mark) begin
			has_result = 1'b1;
			if (!empty) begin
				err_d = 1'b1;
				report.kind = csbc_pkg::RPT_UNCLOSED;
				report.chr  = top_kind_q ? csbc_pkg::CH_LBRACE : csbc_pkg::CH_LPAREN;
				report.line = csbc_pkg::line_out_t'(top_line_q);
			end else begin
				report.chr = '0;
			end
		end else if (overflow) begin
			has_result = 1'b1;
			err_d = 1'b1;
			report.kind = csbc_pkg::RPT_OVERFLOW;
		end else if (unmatched) begin
			has_result = 1'b1;
			err_d = 1'b1;
			report.kind = csbc_pkg::RPT_UNMATCHED;
		end
		report.any_error = err_d;
	end

	// Hold top of stack, depth and sticky error
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
			error_q <= 1'b0;
		end else begin
			depth_q <= depth_d;
			if (advance) error_q <= ev.end_mark ? 1'b0 : err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push_ok) begin
			top_kind_q <= ev.curly;
			top_line_q <= cur_line;
		end else if (advance && pop) begin
			top_kind_q <= below_kind_q;
			top_line_q <= below_line_q;
		end
	end

	`CSBC_ASSERT_NEXT(a_end_clears, advance && ev.end_mark, (depth_q == '0) && !error_q)
	`CSBC_ASSERT_NEXT(a_push_grows, advance && push_ok && !ev.end_mark,
		depth_q == $past(depth_q) + DW'(1))
	`CSBC_ASSERT_NOW(a_overflow_full, has_result && (report.kind == csbc_pkg::RPT_OVERFLOW),
		depth_q == DW'(STACK_DEPTH))

endmodule

// ===== verif/bracket_report_checker.sv =====
// Watches both channels of the bracket checker, predicts each report word and compares it.
`timescale 1ns / 1ps

module bracket_report_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        cmd,
	input  logic [7:0]  char_byte,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  report_kind,
	input  logic [7:0]  bracket_char,
	input  logic [19:0] line_number,
	input  logic        any_error,
	input  logic        drain,
	output int          mismatches,
	output int          backlog
);

	localparam int NEST_MAX = 64;

	// Shadow state of the lexer and the bracket stack
	csbc_pkg::lex_mode_t   mode;
	csbc_pkg::line_out_t   cur_line;
	bit                    open_curly [NEST_MAX];
	csbc_pkg::line_out_t   open_line [NEST_MAX];
	int                    depth;
	bit                    err_flag;

	csbc_pkg::report_t     want_reports [$];
	csbc_pkg::report_t     fresh;
	csbc_pkg::report_t     oldest;

	initial begin
		mismatches = 0;
		backlog    = 0;
	end

	task automatic log_mismatch(input string msg);
		mismatches++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	function automatic void clear_state();
		mode     = csbc_pkg::LEX_NORMAL;
		cur_line = 1;
		depth    = 0;
		err_flag = 0;
	endfunction

	// Advance the line count, holding at the top value
	function automatic void bump_line();
		if (cur_line != '1)
			cur_line++;
	endfunction

	function automatic csbc_pkg::report_t make_report(input csbc_pkg::report_kind_t k,
			input logic [7:0] ch, input csbc_pkg::line_out_t ln);
		csbc_pkg::report_t r;
		r.kind      = k;
		r.chr       = ch;
		r.line      = ln;
		r.any_error = err_flag;
		return r;
	endfunction

	// Handle one byte of plain code: newlines, literal and comment starts, brackets
	function automatic bit scan_code(input logic [7:0] b, output csbc_pkg::report_t r);
		bit hit;
		hit = 0;
		r   = '0;
		case (b)
			csbc_pkg::CH_NL:     bump_line();
			csbc_pkg::CH_SQUOTE: mode = csbc_pkg::LEX_CHR;
			csbc_pkg::CH_DQUOTE: mode = csbc_pkg::LEX_STR;
			csbc_pkg::CH_SLASH:  mode = csbc_pkg::LEX_SLASH;
			csbc_pkg::CH_LPAREN, csbc_pkg::CH_LBRACE: begin
				if (depth >= NEST_MAX) begin
					err_flag = 1;
					r   = make_report(csbc_pkg::RPT_OVERFLOW, b, cur_line);
					hit = 1;
				end else begin
					open_curly[depth] = (b == csbc_pkg::CH_LBRACE);
					open_line[depth]  = cur_line;
					depth++;
				end
			end
			csbc_pkg::CH_RPAREN, csbc_pkg::CH_RBRACE: begin
				if (depth > 0 && open_curly[depth-1] == (b == csbc_pkg::CH_RBRACE)) begin
					depth--;
				end else begin
					err_flag = 1;
					r   = make_report(csbc_pkg::RPT_UNMATCHED, b, cur_line);
					hit = 1;
				end
			end
			default: ;
		endcase
		return hit;
	endfunction

	// Step the shadow state by one input word; return 1 when a report word follows
	function automatic bit predict_report(input logic c, input logic [7:0] b,
			output csbc_pkg::report_t r);
		r = '0;
		if (c == csbc_pkg::CMD_END) begin
			if (depth > 0) begin
				err_flag = 1;
				r = make_report(csbc_pkg::RPT_UNCLOSED,
					open_curly[depth-1] ? csbc_pkg::CH_LBRACE : csbc_pkg::CH_LPAREN,
					open_line[depth-1]);
			end else begin
				r = make_report(csbc_pkg::RPT_CLEAN, 8'h00, cur_line);
			end
			clear_state();
			return 1;
		end
		case (mode)
			csbc_pkg::LEX_CHR: begin
				if (b == csbc_pkg::CH_BSLASH)
					mode = csbc_pkg::LEX_CHR_ESC;
				else if (b == csbc_pkg::CH_SQUOTE)
					mode = csbc_pkg::LEX_NORMAL;
			end
			csbc_pkg::LEX_CHR_ESC: mode = csbc_pkg::LEX_CHR;
			csbc_pkg::LEX_STR: begin
				if (b == csbc_pkg::CH_BSLASH)
					mode = csbc_pkg::LEX_STR_ESC;
				else if (b == csbc_pkg::CH_DQUOTE)
					mode = csbc_pkg::LEX_NORMAL;
			end
			csbc_pkg::LEX_STR_ESC: mode = csbc_pkg::LEX_STR;
			csbc_pkg::LEX_SLASH: begin
				if (b == csbc_pkg::CH_SLASH) begin
					mode = csbc_pkg::LEX_LINE_CMT;
				end else if (b == csbc_pkg::CH_STAR) begin
					mode = csbc_pkg::LEX_BLK_CMT;
				end else begin
					// lone slash: drop it and treat this byte as code
					mode = csbc_pkg::LEX_NORMAL;
					return scan_code(b, r);
				end
			end
			csbc_pkg::LEX_LINE_CMT: begin
				if (b == csbc_pkg::CH_NL) begin
					bump_line();
					mode = csbc_pkg::LEX_NORMAL;
				end
			end
			csbc_pkg::LEX_BLK_CMT: begin
				if (b == csbc_pkg::CH_NL)
					bump_line();
				else if (b == csbc_pkg::CH_STAR)
					mode = csbc_pkg::LEX_BLK_STAR;
			end
			csbc_pkg::LEX_BLK_STAR: begin
				if (b == csbc_pkg::CH_SLASH) begin
					mode = csbc_pkg::LEX_NORMAL;
				end else if (b != csbc_pkg::CH_STAR) begin
					if (b == csbc_pkg::CH_NL)
						bump_line();
					mode = csbc_pkg::LEX_BLK_CMT;
				end
			end
			default: begin
				mode = csbc_pkg::LEX_NORMAL;
				return scan_code(b, r);
			end
		endcase
		return 0;
	endfunction

	// Compare report words in order, then predict from the accepted source word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			want_reports.delete();
		end else begin
			if (out_valid && out_ready) begin
				if (want_reports.size() == 0) begin
					log_mismatch($sformatf("report word with none expected: kind %0d char %02h",
						report_kind, bracket_char));
				end else begin
					oldest = want_reports.pop_front();
					if (report_kind !== oldest.kind)
						log_mismatch($sformatf("report_kind %0d, expected %0d",
							report_kind, oldest.kind));
					if (bracket_char !== oldest.chr)
						log_mismatch($sformatf("bracket_char %02h, expected %02h",
							bracket_char, oldest.chr));
					if (line_number !== oldest.line)
						log_mismatch($sformatf("line_number %0d, expected %0d",
							line_number, oldest.line));
					if (any_error !== oldest.any_error)
						log_mismatch($sformatf("any_error %0b, expected %0b",
							any_error, oldest.any_error));
				end
			end
			if (in_valid && in_ready) begin
				if (predict_report(cmd, char_byte, fresh))
					want_reports.push_back(fresh);
			end
		end
		backlog = want_reports.size();
	end

	// Flag reports still owed once the run has drained
	always @(posedge drain) begin
		if (want_reports.size() != 0)
			log_mismatch($sformatf("%0d expected report words never arrived",
				want_reports.size()));
	end

endmodule

// ===== verif/tb.sv =====
// Top of the bracket checker testbench: clock, reset, source stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps

module tb;

	localparam int RANDOM_WORDS = 1400;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        cmd;
	logic [7:0]  char_byte;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  report_kind;
	logic [7:0]  bracket_char;
	logic [19:0] line_number;
	logic        any_error;
	logic        drain;

	int          mismatches;
	int          backlog;
	int          sent;
	int          burst_left;
	int          rx_mode;
	int          rx_left;

	c_source_bracket_checker u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.char_byte    (char_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.report_kind  (report_kind),
		.bracket_char (bracket_char),
		.line_number  (line_number),
		.any_error    (any_error)
	);

	bracket_report_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.char_byte    (char_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.report_kind  (report_kind),
		.bracket_char (bracket_char),
		.line_number  (line_number),
		.any_error    (any_error),
		.drain        (drain),
		.mismatches   (mismatches),
		.backlog      (backlog)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: switch between stall patterns every so often
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0:       out_ready <= 1'b1;
			1:       out_ready <= ~out_ready;
			2:       out_ready <= ($urandom_range(0, 9) < 7);
			default: out_ready <= ($urandom_range(0, 15) == 0);
		endcase
	end

	// Sender pacing: bursts of random length, random gaps between them
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
	endtask

	// Present one word and hold it until accepted
	task automatic send_word(input logic c, input logic [7:0] b);
		pace();
		in_valid  <= 1'b1;
		cmd       <= c;
		char_byte <= b;
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_word(csbc_pkg::CMD_BYTE, b);
	endtask

	task automatic send_end();
		send_word(csbc_pkg::CMD_END, 8'($urandom_range(0, 255)));
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_byte(s[i]);
	endtask

	// Byte for literal or comment bodies: brackets, newlines, slashes, stars, plain text
	function automatic logic [7:0] body_byte();
		case ($urandom_range(0, 9))
			0:       return csbc_pkg::CH_LPAREN;
			1:       return csbc_pkg::CH_RPAREN;
			2:       return csbc_pkg::CH_LBRACE;
			3:       return csbc_pkg::CH_RBRACE;
			4:       return csbc_pkg::CH_NL;
			5:       return csbc_pkg::CH_SLASH;
			6:       return csbc_pkg::CH_STAR;
			7:       return 8'h20;
			default: return 8'($urandom_range(8'h61, 8'h7A));
		endcase
	endfunction

	// Quoted literal with escapes, closed most of the time
	task automatic send_literal(input logic [7:0] quote);
		int n;
		n = $urandom_range(0, 8);
		send_byte(quote);
		repeat (n) begin
			if ($urandom_range(0, 4) == 0) begin
				send_byte(csbc_pkg::CH_BSLASH);
				case ($urandom_range(0, 4))
					0:       send_byte(quote);
					1:       send_byte(csbc_pkg::CH_BSLASH);
					2:       send_byte(csbc_pkg::CH_NL);
					default: send_byte(8'($urandom_range(0, 255)));
				endcase
			end else begin
				send_byte(body_byte());
			end
		end
		if ($urandom_range(0, 7) != 0)
			send_byte(quote);
	endtask

	// One random source stream of code-like tokens, ended by an end marker
	task automatic send_stream();
		logic [7:0] nest [$];
		logic [7:0] ch;
		int         ntok;
		int         pick;
		ntok = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(5, 40);
		repeat (ntok) begin
			pick = $urandom_range(0, 99);
			if (pick < 22) begin
				ch = $urandom_range(0, 1) ? csbc_pkg::CH_LPAREN : csbc_pkg::CH_LBRACE;
				nest.push_back(ch);
				send_byte(ch);
			end else if (pick < 40) begin
				if (nest.size() > 0 && $urandom_range(0, 9) != 0) begin
					ch = nest.pop_back();
					send_byte(ch == csbc_pkg::CH_LPAREN ? csbc_pkg::CH_RPAREN
						: csbc_pkg::CH_RBRACE);
				end else begin
					send_byte($urandom_range(0, 1) ? csbc_pkg::CH_RPAREN
						: csbc_pkg::CH_RBRACE);
				end
			end else if (pick < 50) begin
				send_byte(csbc_pkg::CH_NL);
			end else if (pick < 58) begin
				send_literal(csbc_pkg::CH_DQUOTE);
			end else if (pick < 63) begin
				send_literal(csbc_pkg::CH_SQUOTE);
			end else if (pick < 70) begin
				send_byte(csbc_pkg::CH_SLASH);
				send_byte(csbc_pkg::CH_SLASH);
				repeat ($urandom_range(0, 8)) send_byte(body_byte());
				if ($urandom_range(0, 7) != 0)
					send_byte(csbc_pkg::CH_NL);
			end else if (pick < 77) begin
				send_byte(csbc_pkg::CH_SLASH);
				send_byte(csbc_pkg::CH_STAR);
				repeat ($urandom_range(0, 10)) send_byte(body_byte());
				if ($urandom_range(0, 7) != 0) begin
					repeat ($urandom_range(1, 3)) send_byte(csbc_pkg::CH_STAR);
					send_byte(csbc_pkg::CH_SLASH);
				end
			end else if (pick < 82) begin
				// lone slash, then a byte that must be seen as code
				send_byte(csbc_pkg::CH_SLASH);
				case ($urandom_range(0, 4))
					0:       send_byte(csbc_pkg::CH_LPAREN);
					1:       send_byte(csbc_pkg::CH_RBRACE);
					2:       send_byte(csbc_pkg::CH_NL);
					3:       send_byte(csbc_pkg::CH_DQUOTE);
					default: send_byte(8'($urandom_range(8'h61, 8'h7A)));
				endcase
			end else if (pick < 92) begin
				send_byte($urandom_range(0, 1) ? 8'h3B : 8'($urandom_range(8'h61, 8'h7A)));
			end else begin
				send_byte(8'($urandom_range(0, 255)));
			end
		end
		// close what is still open, most of the time
		if ($urandom_range(0, 3) != 0) begin
			while (nest.size() > 0) begin
				ch = nest.pop_back();
				send_byte(ch == csbc_pkg::CH_LPAREN ? csbc_pkg::CH_RPAREN
					: csbc_pkg::CH_RBRACE);
			end
		end
		send_end();
	endtask

	initial begin
		int stop_at;
		clk        = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cmd        = csbc_pkg::CMD_BYTE;
		char_byte  = 8'h00;
		out_ready  = 1'b0;
		drain      = 1'b0;
		sent       = 0;
		burst_left = 0;
		rx_mode    = 0;
		rx_left    = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: clean end, mismatch, pop, stray closer
		send_end();
		send_text("(\n{)})}");
		send_end();
		// Literals with escapes and an uncounted newline, then a stray closer
		send_text("'('\"\\\"(\n\"'\\\\')");
		// Lone slash, line comment, slash star slash left open, star run and newline inside, then close
		send_text("/(//})\n/*/)**\n*/)");
		send_byte(8'h00);
		send_byte(8'hFF);
		send_text("{");
		send_end();
		// End marker in every lexer mode but plain code and a character literal
		send_text("/*(");
		send_end();
		send_text("/**");
		send_end();
		send_text("\"{");
		send_end();
		send_text("\"\\");
		send_end();
		send_text("'\\");
		send_end();
		send_text("/");
		send_end();
		send_text("//(");
		send_end();

		// Full stack: extra openers are reported and not pushed
		repeat (64) send_byte(csbc_pkg::CH_LPAREN);
		send_byte(csbc_pkg::CH_LPAREN);
		send_byte(csbc_pkg::CH_LBRACE);
		send_byte(csbc_pkg::CH_RPAREN);
		send_end();

		// Random streams
		stop_at = sent + RANDOM_WORDS;
		while (sent < stop_at)
			send_stream();
		in_valid <= 1'b0;

		// Drain outstanding reports, then allow for stray words
		while (backlog != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		drain <= 1'b1;
		@(posedge clk);
		@(posedge clk);
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Hard stop in case the run hangs
	initial begin
		#5_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
